// ===== sv/i2c_sbs_pkg.sv =====
// Package: types and constants shared by the I2C slave byte sequencer files.
`timescale 1ns / 1ps

package i2c_sbs_pkg;

    // Sequencer phase, one per byte or ack step on the bus
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_ADDR      = 4'd1,
        PH_ADDR_ACK  = 4'd2,
        PH_RX        = 4'd3,
        PH_RX_ACK    = 4'd4,
        PH_TX        = 4'd5,
        PH_TX_ACK    = 4'd6,
        PH_TEST_ACK  = 4'd7,
        PH_NACK_DONE = 4'd8
    } t_phase;

    // Shift register load values
    localparam logic [7:0] VAL_ACK  = 8'h00;
    localparam logic [7:0] VAL_NACK = 8'hFF;

    // Bit counts for the shift unit
    localparam logic [3:0] BITS_NONE = 4'd0;
    localparam logic [3:0] BITS_ACK  = 4'd1;
    localparam logic [3:0] BITS_BYTE = 4'd8;

    // One shift event
    typedef struct packed {
        logic       start_flag;
        logic [7:0] shift_data;
        logic [7:0] tx_data;
    } t_in_item;

    // One result
    typedef struct packed {
        logic       start_notice;
        logic       sda_drive;
        logic       shift_load;
        logic [7:0] shift_value;
        logic [3:0] bit_count;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_taken;
        logic [3:0] phase_out;
    } t_out_item;

endpackage

// ===== sv/i2c_sbs_if.sv =====
// Interfaces: event input, result output and address configuration channels.
`timescale 1ns / 1ps

interface i2c_sbs_in_if;
    logic       valid;
    logic       ready;
    logic       start_flag;
    logic [7:0] shift_data;
    logic [7:0] tx_data;

    modport source (output valid, start_flag, shift_data, tx_data, input ready);
    modport sink   (input valid, start_flag, shift_data, tx_data, output ready);
endinterface

interface i2c_sbs_out_if;
    logic       valid;
    logic       ready;
    logic       start_notice;
    logic       sda_drive;
    logic       shift_load;
    logic [7:0] shift_value;
    logic [3:0] bit_count;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_taken;
    logic [3:0] phase_out;

    modport source (output valid, start_notice, sda_drive, shift_load, shift_value,
                    bit_count, rx_valid, rx_byte, tx_taken, phase_out, input ready);
    modport sink   (input valid, start_notice, sda_drive, shift_load, shift_value,
                    bit_count, rx_valid, rx_byte, tx_taken, phase_out, output ready);
endinterface

interface i2c_sbs_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] dev_addr;

    modport source (output valid, dev_addr, input ready);
    modport sink   (input valid, dev_addr, output ready);
endinterface

// ===== sv/i2c_sbs_in_stage.sv =====
// Input register stage: captures one event item and hands it to the step stage.
`timescale 1ns / 1ps

module i2c_sbs_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  i2c_sbs_pkg::t_in_item i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output i2c_sbs_pkg::t_in_item o_item
);
    import i2c_sbs_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;
    logic     w_load;

    // Accept when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== sv/i2c_sbs_step.sv =====
// Step stage: phase and SDA-drive state, next-result logic and result register.
`timescale 1ns / 1ps

module i2c_sbs_step (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [6:0]             i_dev_addr,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  i2c_sbs_pkg::t_in_item  i_item,
    output logic                   o_valid,
    input  logic                   i_ready,
    output i2c_sbs_pkg::t_out_item o_item
);
    import i2c_sbs_pkg::*;

    t_phase    r_phase;
    t_phase    n_phase;
    logic      r_sda;
    logic      n_sda;
    logic      r_valid;
    logic      n_valid;
    t_out_item r_res;
    t_out_item n_res;
    t_phase    w_cur;
    logic      w_do_tx;
    logic      w_adv;

    // Output register frees when empty or taken
    assign o_ready = !r_valid || i_ready;
    assign w_adv   = i_valid && o_ready;

    // Next state and result for the item at the input
    always_comb begin
        w_cur   = i_item.start_flag ? PH_ADDR : r_phase;
        n_phase = w_cur;
        n_sda   = r_sda;
        w_do_tx = 1'b0;
        n_res   = '0;
        n_res.start_notice = i_item.start_flag;

        case (w_cur)
            PH_ADDR: begin
                n_res.bit_count = BITS_BYTE;
                n_phase         = PH_ADDR_ACK;
            end
            PH_ADDR_ACK: begin
                n_res.shift_load = 1'b1;
                n_res.bit_count  = BITS_ACK;
                if (i_item.shift_data[7:1] == i_dev_addr) begin
                    n_sda             = 1'b1;
                    n_res.shift_value = VAL_ACK;
                    n_phase           = i_item.shift_data[0] ? PH_TX : PH_RX;
                end else begin
                    n_res.shift_value = VAL_NACK;
                    n_phase           = PH_NACK_DONE;
                end
            end
            PH_RX: begin
                n_sda           = 1'b0;
                n_res.bit_count = BITS_BYTE;
                n_phase         = PH_RX_ACK;
            end
            PH_RX_ACK: begin
                n_res.rx_valid    = 1'b1;
                n_res.rx_byte     = i_item.shift_data;
                n_sda             = 1'b1;
                n_res.shift_load  = 1'b1;
                n_res.shift_value = VAL_ACK;
                n_res.bit_count   = BITS_ACK;
                n_phase           = PH_RX;
            end
            PH_TX: begin
                w_do_tx = 1'b1;
            end
            PH_TX_ACK: begin
                n_sda           = 1'b0;
                n_res.bit_count = BITS_ACK;
                n_phase         = PH_TEST_ACK;
            end
            PH_TEST_ACK: begin
                // master NACK ends the read, ACK asks for another byte
                if (i_item.shift_data[0]) begin
                    n_phase = PH_IDLE;
                end else begin
                    w_do_tx = 1'b1;
                end
            end
            PH_NACK_DONE: begin
                n_sda   = 1'b0;
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // Load the offered byte for transmission
        if (w_do_tx) begin
            n_sda             = 1'b1;
            n_res.tx_taken    = 1'b1;
            n_res.shift_load  = 1'b1;
            n_res.shift_value = i_item.tx_data;
            n_res.bit_count   = BITS_BYTE;
            n_phase           = PH_TX_ACK;
        end

        n_res.sda_drive = n_sda;
        n_res.phase_out = n_phase;
    end

    // Output valid
    always_comb begin
        n_valid = r_valid;
        if (w_adv) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sda   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (w_adv) begin
                r_phase <= n_phase;
                r_sda   <= n_sda;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_res;

endmodule

// ===== sv/i2c_slave_byte_sequencer.sv =====
// Top level: I2C slave byte sequencer with input register, step stage and address register.
//
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+------------------------------------------------
//  i_in     | in  | valid/ready | start_flag, shift_data, tx_data
//  o_out    | out | valid/ready | start_notice, sda_drive, shift_load, shift_value,
//           |     |             | bit_count, rx_valid, rx_byte, tx_taken, phase_out
//  i_cfg    | in  | valid/ready | dev_addr
//
//  An event item is accepted every cycle when the output side keeps up; an accepted item
//  is loaded into the input register and its result then into the result register, so
//  a result passes through both registers before it reaches the output.
//  Synchronous active-low reset clears valids, phase (idle), SDA drive and address.
//  A stalled output holds its result; the input register keeps taking one more item.
//  The configuration channel is always ready.
`timescale 1ns / 1ps

module i2c_slave_byte_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    i2c_sbs_in_if.sink           i_in,
    i2c_sbs_out_if.source        o_out,
    i2c_sbs_cfg_if.sink          i_cfg
);
    import i2c_sbs_pkg::*;

    logic [6:0] r_dev_addr;
    t_in_item  w_in_item;
    t_in_item  w_stg_item;
    logic      w_stg_valid;
    logic      w_stg_ready;
    t_out_item w_res;

    // Address register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= '0;
        end else if (i_cfg.valid) begin
            r_dev_addr <= i_cfg.dev_addr;
        end
    end

    assign w_in_item.start_flag = i_in.start_flag;
    assign w_in_item.shift_data = i_in.shift_data;
    assign w_in_item.tx_data    = i_in.tx_data;

    i2c_sbs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (w_in_item),
        .o_valid (w_stg_valid),
        .i_ready (w_stg_ready),
        .o_item  (w_stg_item)
    );

    i2c_sbs_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dev_addr (r_dev_addr),
        .i_valid    (w_stg_valid),
        .o_ready    (w_stg_ready),
        .i_item     (w_stg_item),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_item     (w_res)
    );

    // Result fields out
    assign o_out.start_notice = w_res.start_notice;
    assign o_out.sda_drive    = w_res.sda_drive;
    assign o_out.shift_load   = w_res.shift_load;
    assign o_out.shift_value  = w_res.shift_value;
    assign o_out.bit_count    = w_res.bit_count;
    assign o_out.rx_valid     = w_res.rx_valid;
    assign o_out.rx_byte      = w_res.rx_byte;
    assign o_out.tx_taken     = w_res.tx_taken;
    assign o_out.phase_out    = w_res.phase_out;

endmodule

// ===== sv/i2c_sbs_chk.sv =====
// Checker: port-level properties of the I2C slave byte sequencer, bound to the top level.
`timescale 1ns / 1ps

module i2c_sbs_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_sda_drive,
    input logic       i_shift_load,
    input logic [7:0] i_shift_value,
    input logic [3:0] i_bit_count,
    input logic       i_rx_valid,
    input logic [7:0] i_rx_byte,
    input logic       i_tx_taken,
    input logic [3:0] i_phase_out
);
    import i2c_sbs_pkg::*;

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_shift_value)
            && $stable(i_phase_out) && $stable(i_rx_byte))
        else $error("result changed under stall");

    // No load means a zero load value, no received byte means zero data
    a_zero_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_shift_load || i_shift_value == VAL_ACK)
            && (i_rx_valid || i_rx_byte == 8'h00))
        else $error("unused result field not zero");

    // A taken transmit byte drives SDA, shifts a byte and waits for the master ack
    a_tx_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_tx_taken |-> i_sda_drive && i_shift_load
            && i_bit_count == BITS_BYTE && i_phase_out == PH_TX_ACK)
        else $error("transmit result inconsistent");

    // Received byte comes with an ACK load and a return to receive
    a_rx_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_rx_valid |-> i_sda_drive && i_shift_load
            && i_shift_value == VAL_ACK && i_bit_count == BITS_ACK && i_phase_out == PH_RX)
        else $error("receive result inconsistent");

    // Bit count is one of the legal counts
    a_bit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_bit_count == BITS_NONE || i_bit_count == BITS_ACK
            || i_bit_count == BITS_BYTE)
        else $error("illegal bit count");

endmodule

bind i2c_slave_byte_sequencer i2c_sbs_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_sda_drive   (o_out.sda_drive),
    .i_shift_load  (o_out.shift_load),
    .i_shift_value (o_out.shift_value),
    .i_bit_count   (o_out.bit_count),
    .i_rx_valid    (o_out.rx_valid),
    .i_rx_byte     (o_out.rx_byte),
    .i_tx_taken    (o_out.tx_taken),
    .i_phase_out   (o_out.phase_out)
);
